FILE: rtl/fidl_pkg.sv
// ----------------------------------------------------------------------------
// fidl_pkg
// Shared types and constants of the ID free-list allocator.
// ----------------------------------------------------------------------------
package fidl_pkg;

  localparam int ID_W        = 8;
  localparam int OWNER_W     = 16;
  localparam int STAT_W      = 2;
  localparam int TYPE_W      = 3;
  localparam int RING_DEPTH  = 32;
  localparam int RING_AW     = 5;
  localparam int RING_CW     = 6;
  localparam int MAX_RESULTS = 32;
  localparam int N_W         = 6;

  typedef enum logic [TYPE_W-1:0] {
    REQ_RESERVE   = 3'd0,
    REQ_ALLOC     = 3'd1,
    REQ_RELEASE   = 3'd2,
    REQ_LIST_FREE = 3'd3,
    REQ_LIST_USED = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_FSCAN,
    S_SHIFT,
    S_RSVW,
    S_ALRD,
    S_ALWR,
    S_RELW,
    S_RSCAN,
    S_LFRD,
    S_LFCAP,
    S_LSCAN,
    S_LPASS,
    S_LFIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
    logic               wr_en;
    logic [RING_AW-1:0] wr_addr;
    logic [ID_W-1:0]    wr_data;
  } ring_ctrl_t;

  typedef struct packed {
    logic eq;
    logic gt;
    logic lt;
  } cmp_res_t;

  typedef struct packed {
    logic [ID_W-1:0]    ident;
    logic [OWNER_W-1:0] owner;
  } used_ent_t;

endpackage

FILE: rtl/fidl_cmp.sv
// ----------------------------------------------------------------------------
// fidl_cmp
// Shared key comparator: candidate against a lower and an upper bound.
// ----------------------------------------------------------------------------
module fidl_cmp #(
  parameter int KEY_W = 13
) (
  input  logic [KEY_W-1:0]  cand,
  input  logic [KEY_W-1:0]  lo,
  input  logic [KEY_W-1:0]  hi,
  output fidl_pkg::cmp_res_t res
);
  import fidl_pkg::*;

  assign res.eq = (cand == lo);
  assign res.gt = (cand > lo);
  assign res.lt = (cand < hi);

endmodule

FILE: rtl/fidl_ring.sv
// ----------------------------------------------------------------------------
// fidl_ring
// Free-ID ring memory, one read and one write port, registered read.
// Entries never written read back as their power-on ID.
// ----------------------------------------------------------------------------
module fidl_ring #(
  parameter int INITIAL_IDS = 20,
  parameter int FIRST_ID    = 101
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fidl_pkg::ring_ctrl_t      ctrl,
  output logic [fidl_pkg::ID_W-1:0] rd_data
);
  import fidl_pkg::*;

  logic [ID_W-1:0]       mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] wr_seen_r;
  logic [ID_W-1:0]       rd_q_r;
  logic                  rd_init_r;
  logic [RING_AW-1:0]    rd_addr_r;
  logic [ID_W-1:0]       init_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_seen_r <= '0;
    end else if (ctrl.wr_en) begin
      wr_seen_r[ctrl.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q_r    <= mem[ctrl.rd_addr];
      rd_init_r <= !wr_seen_r[ctrl.rd_addr];
      rd_addr_r <= ctrl.rd_addr;
    end
  end

  always_comb begin
    if ({1'b0, rd_addr_r} < RING_CW'(INITIAL_IDS)) begin
      init_val = ID_W'(FIRST_ID + int'(rd_addr_r));
    end else begin
      init_val = '0;
    end
  end

  assign rd_data = rd_init_r ? init_val : rd_q_r;

endmodule

FILE: rtl/fifo_id_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fifo_id_free_list_allocator
// ID allocator: FIFO free list of IDs plus a table of used (ID, owner) entries.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ready is high only between requests, and
// each result goes through an output register, so the next request can enter
// while the final item still waits on out_ready. All searches run one table
// entry per cycle; the ID searches share a single key comparator. Allocate
// runs the free-slot search, then reads the head of the free list and writes
// the used entry; reserve follows the free-slot search with a scan of the free
// list and, when the ID is found, a one-entry-per-cycle compaction behind it;
// release appends the ID to the free list, then scans the used table; list
// free reads and emits each free ID in turn; list used makes one full pass of
// the used table per listed entry. Output stalls lengthen each request. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fifo_id_free_list_allocator #(
  parameter int INITIAL_IDS = 20,
  parameter int FIRST_ID    = 101,
  parameter int STORE_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fidl_pkg::TYPE_W-1:0]  in_req_type,
  input  logic [fidl_pkg::OWNER_W-1:0] in_owner_tag,
  input  logic [fidl_pkg::ID_W-1:0]    in_ident,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fidl_pkg::ID_W-1:0]    out_ident,
  output logic [fidl_pkg::OWNER_W-1:0] out_owner,
  output logic [fidl_pkg::STAT_W-1:0]  out_status,
  output logic                         out_last
);
  import fidl_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CW    = (AW + 1 > RING_CW) ? AW + 1 : RING_CW;
  localparam int KEY_W = ID_W + AW;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [TYPE_W-1:0]      type_r, type_nxt;
  logic [OWNER_W-1:0]     owner_r, owner_nxt;
  logic [ID_W-1:0]        ident_r, ident_nxt;
  logic [RING_AW-1:0]     head_r, head_nxt;
  logic [RING_CW-1:0]     count_r, count_nxt;
  logic [STORE_DEPTH-1:0] used_valid_r, used_valid_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   chk_v_r, chk_v_nxt;
  logic [CW-1:0]          chk_i_r, chk_i_nxt;
  logic [AW-1:0]          slot_r, slot_nxt;
  logic                   found_r, found_nxt;
  logic [N_W-1:0]         n_r, n_nxt;
  logic [KEY_W-1:0]       prev_key_r, prev_key_nxt;
  logic                   have_prev_r, have_prev_nxt;
  logic [KEY_W-1:0]       best_key_r, best_key_nxt;
  logic [OWNER_W-1:0]     best_owner_r, best_owner_nxt;
  logic                   best_found_r, best_found_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]        pend_ident_r, pend_ident_nxt;
  logic [OWNER_W-1:0]     pend_owner_r, pend_owner_nxt;
  logic [ID_W-1:0]        res_ident_r, res_ident_nxt;
  logic [OWNER_W-1:0]     res_owner_r, res_owner_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   res_last_r, res_last_nxt;

  logic                   out_valid_r;
  logic [ID_W-1:0]        out_ident_r;
  logic [OWNER_W-1:0]     out_owner_r;
  logic [STAT_W-1:0]      out_status_r;
  logic                   out_last_r;

  used_ent_t              used_mem [STORE_DEPTH];
  used_ent_t              um_q_r;
  logic                   um_rd_en;
  logic [AW-1:0]          um_rd_addr;
  logic                   um_wr_en;
  logic [AW-1:0]          um_wr_addr;
  used_ent_t              um_wr_data;

  ring_ctrl_t             ring_ctrl;
  logic [ID_W-1:0]        ring_rd_data;

  logic [KEY_W-1:0]       cand_key, lo_key, hi_key;
  cmp_res_t               cmp;

  logic                   accept, out_free, load_out;
  logic                   ring_issue, used_issue, ring_done, used_done;
  logic [AW-1:0]          cur_slot, chk_slot;
  logic                   slot_free, slot_last, chk_used_v;
  logic                   hit_ring, hit_used, better;

  // --------------------------------------------------------------------------
  fidl_ring #(
    .INITIAL_IDS (INITIAL_IDS),
    .FIRST_ID    (FIRST_ID)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ring_ctrl),
    .rd_data (ring_rd_data)
  );

  fidl_cmp #(
    .KEY_W (KEY_W)
  ) u_cmp (
    .cand (cand_key),
    .lo   (lo_key),
    .hi   (hi_key),
    .res  (cmp)
  );

  always_ff @(posedge clk) begin
    if (um_wr_en) begin
      used_mem[um_wr_addr] <= um_wr_data;
    end
    if (um_rd_en) begin
      um_q_r <= used_mem[um_rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign load_out   = (state_r == S_EMIT) && out_free;

  assign ring_issue = cnt_r < CW'(count_r);
  assign used_issue = cnt_r < CW'(STORE_DEPTH);
  assign ring_done  = !ring_issue && !chk_v_r;
  assign used_done  = !used_issue && !chk_v_r;
  assign cur_slot   = cnt_r[AW-1:0];
  assign chk_slot   = chk_i_r[AW-1:0];
  assign slot_free  = !used_valid_r[cur_slot];
  assign slot_last  = (cnt_r == CW'(STORE_DEPTH - 1));
  assign chk_used_v = used_valid_r[chk_slot];

  always_comb begin
    cand_key = '0;
    lo_key   = '0;
    hi_key   = '0;
    case (state_r)
      S_FSCAN: begin
        cand_key = {ring_rd_data, {AW{1'b0}}};
        lo_key   = {ident_r, {AW{1'b0}}};
      end
      S_RSCAN: begin
        cand_key = {um_q_r.ident, {AW{1'b0}}};
        lo_key   = {ident_r, {AW{1'b0}}};
      end
      S_LSCAN: begin
        cand_key = {um_q_r.ident, chk_slot};
        lo_key   = prev_key_r;
        hi_key   = best_key_r;
      end
      default: ;
    endcase
  end

  assign hit_ring = chk_v_r && cmp.eq;
  assign hit_used = chk_v_r && chk_used_v && cmp.eq;
  assign better   = chk_v_r && chk_used_v && (!have_prev_r || cmp.gt) &&
                    (!best_found_r || cmp.lt);

  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_RESERVE:   state_nxt = S_SLOT;
            REQ_ALLOC:     state_nxt = (count_r == '0) ? S_EMIT : S_SLOT;
            REQ_RELEASE:   state_nxt = (count_r == RING_CW'(RING_DEPTH)) ? S_EMIT : S_RELW;
            REQ_LIST_FREE: state_nxt = (count_r == '0) ? S_EMIT : S_LFRD;
            REQ_LIST_USED: state_nxt = S_LSCAN;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_SLOT: begin
        if (slot_free) begin
          state_nxt = (type_r == REQ_RESERVE) ? S_FSCAN : S_ALRD;
        end else if (slot_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_FSCAN: begin
        if (hit_ring) begin
          state_nxt = S_SHIFT;
        end else if (ring_done) begin
          state_nxt = S_RSVW;
        end
      end
      S_SHIFT: if (ring_done) state_nxt = S_RSVW;
      S_RSVW:  state_nxt = S_EMIT;
      S_ALRD:  state_nxt = S_ALWR;
      S_ALWR:  state_nxt = S_EMIT;
      S_RELW:  state_nxt = S_RSCAN;
      S_RSCAN: if (hit_used || used_done) state_nxt = S_EMIT;
      S_LFRD:  state_nxt = S_LFCAP;
      S_LFCAP: state_nxt = S_EMIT;
      S_LSCAN: if (used_done) state_nxt = S_LPASS;
      S_LPASS: begin
        if (best_found_r) begin
          if (pend_v_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = (n_r == N_W'(MAX_RESULTS - 1)) ? S_LFIN : S_LSCAN;
          end
        end else begin
          state_nxt = pend_v_r ? S_LFIN : S_EMIT;
        end
      end
      S_LFIN:  state_nxt = S_EMIT;
      S_EMIT:  if (out_free) state_nxt = ret_r;
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  always_comb begin
    ret_nxt        = ret_r;
    type_nxt       = type_r;
    owner_nxt      = owner_r;
    ident_nxt      = ident_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    used_valid_nxt = used_valid_r;
    cnt_nxt        = cnt_r;
    chk_v_nxt      = 1'b0;
    chk_i_nxt      = chk_i_r;
    slot_nxt       = slot_r;
    found_nxt      = found_r;
    n_nxt          = n_r;
    prev_key_nxt   = prev_key_r;
    have_prev_nxt  = have_prev_r;
    best_key_nxt   = best_key_r;
    best_owner_nxt = best_owner_r;
    best_found_nxt = best_found_r;
    pend_v_nxt     = pend_v_r;
    pend_ident_nxt = pend_ident_r;
    pend_owner_nxt = pend_owner_r;
    res_ident_nxt  = res_ident_r;
    res_owner_nxt  = res_owner_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    ring_ctrl      = '0;
    um_rd_en       = 1'b0;
    um_rd_addr     = cur_slot;
    um_wr_en       = 1'b0;
    um_wr_addr     = slot_r;
    um_wr_data     = '{ident: ident_r, owner: owner_r};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          type_nxt       = in_req_type;
          owner_nxt      = in_owner_tag;
          ident_nxt      = in_ident;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          n_nxt          = '0;
          have_prev_nxt  = 1'b0;
          best_found_nxt = 1'b0;
          pend_v_nxt     = 1'b0;
          ret_nxt        = S_IDLE;
          res_ident_nxt  = '0;
          res_owner_nxt  = '0;
          res_last_nxt   = 1'b1;
          res_status_nxt = STAT_EMPTY;
          if (in_req_type == REQ_RELEASE) begin
            res_ident_nxt  = in_ident;
            res_status_nxt = STAT_FULL;
          end
        end
      end
      S_SLOT: begin
        if (slot_free) begin
          slot_nxt = cur_slot;
          cnt_nxt  = '0;
        end else if (slot_last) begin
          res_ident_nxt  = (type_r == REQ_RESERVE) ? ident_r : '0;
          res_owner_nxt  = '0;
          res_status_nxt = STAT_FULL;
          res_last_nxt   = 1'b1;
          ret_nxt        = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FSCAN: begin
        ring_ctrl.rd_en   = ring_issue;
        ring_ctrl.rd_addr = head_r + cnt_r[RING_AW-1:0];
        chk_i_nxt         = cnt_r;
        if (ring_issue) begin
          cnt_nxt   = cnt_r + 1'b1;
          chk_v_nxt = 1'b1;
        end
        if (hit_ring) begin
          found_nxt = 1'b1;
          cnt_nxt   = chk_i_r + 1'b1;
          chk_v_nxt = 1'b0;
        end
      end
      S_SHIFT: begin
        // pull every entry behind the match one place towards the head
        ring_ctrl.rd_en   = ring_issue;
        ring_ctrl.rd_addr = head_r + cnt_r[RING_AW-1:0];
        ring_ctrl.wr_en   = chk_v_r;
        ring_ctrl.wr_addr = head_r + chk_i_r[RING_AW-1:0] - 1'b1;
        ring_ctrl.wr_data = ring_rd_data;
        chk_i_nxt         = cnt_r;
        if (ring_issue) begin
          cnt_nxt   = cnt_r + 1'b1;
          chk_v_nxt = 1'b1;
        end
        if (ring_done) begin
          count_nxt = count_r - 1'b1;
        end
      end
      S_RSVW: begin
        um_wr_en                = 1'b1;
        used_valid_nxt[slot_r]  = 1'b1;
        res_ident_nxt           = ident_r;
        res_owner_nxt           = owner_r;
        res_status_nxt          = found_r ? STAT_OK : STAT_NOT_FOUND;
        res_last_nxt            = 1'b1;
        ret_nxt                 = S_IDLE;
      end
      S_ALRD: begin
        ring_ctrl.rd_en   = 1'b1;
        ring_ctrl.rd_addr = head_r;
      end
      S_ALWR: begin
        head_nxt               = head_r + 1'b1;
        count_nxt              = count_r - 1'b1;
        um_wr_en               = 1'b1;
        um_wr_data             = '{ident: ring_rd_data, owner: owner_r};
        used_valid_nxt[slot_r] = 1'b1;
        res_ident_nxt          = ring_rd_data;
        res_owner_nxt          = owner_r;
        res_status_nxt         = STAT_OK;
        res_last_nxt           = 1'b1;
        ret_nxt                = S_IDLE;
      end
      S_RELW: begin
        ring_ctrl.wr_en   = 1'b1;
        ring_ctrl.wr_addr = head_r + count_r[RING_AW-1:0];
        ring_ctrl.wr_data = ident_r;
        count_nxt         = count_r + 1'b1;
        cnt_nxt           = '0;
      end
      S_RSCAN: begin
        um_rd_en  = used_issue;
        chk_i_nxt = cnt_r;
        if (used_issue) begin
          cnt_nxt   = cnt_r + 1'b1;
          chk_v_nxt = 1'b1;
        end
        res_ident_nxt = ident_r;
        res_owner_nxt = '0;
        res_last_nxt  = 1'b1;
        ret_nxt       = S_IDLE;
        if (hit_used) begin
          used_valid_nxt[chk_slot] = 1'b0;
          res_status_nxt           = STAT_OK;
        end else begin
          res_status_nxt = STAT_NOT_FOUND;
        end
      end
      S_LFRD: begin
        ring_ctrl.rd_en   = 1'b1;
        ring_ctrl.rd_addr = head_r + cnt_r[RING_AW-1:0];
      end
      S_LFCAP: begin
        res_ident_nxt  = ring_rd_data;
        res_owner_nxt  = '0;
        res_status_nxt = STAT_OK;
        res_last_nxt   = (cnt_r == CW'(count_r - 1'b1));
        ret_nxt        = (cnt_r == CW'(count_r - 1'b1)) ? S_IDLE : S_LFRD;
        cnt_nxt        = cnt_r + 1'b1;
      end
      S_LSCAN: begin
        um_rd_en  = used_issue;
        chk_i_nxt = cnt_r;
        if (used_issue) begin
          cnt_nxt   = cnt_r + 1'b1;
          chk_v_nxt = 1'b1;
        end
        if (better) begin
          best_key_nxt   = {um_q_r.ident, chk_slot};
          best_owner_nxt = um_q_r.owner;
          best_found_nxt = 1'b1;
        end
      end
      S_LPASS: begin
        // the held entry goes out only once the next one is known
        cnt_nxt        = '0;
        best_found_nxt = 1'b0;
        if (best_found_r) begin
          n_nxt          = n_r + 1'b1;
          prev_key_nxt   = best_key_r;
          have_prev_nxt  = 1'b1;
          pend_v_nxt     = 1'b1;
          pend_ident_nxt = best_key_r[KEY_W-1 -: ID_W];
          pend_owner_nxt = best_owner_r;
          if (pend_v_r) begin
            res_ident_nxt  = pend_ident_r;
            res_owner_nxt  = pend_owner_r;
            res_status_nxt = STAT_OK;
            res_last_nxt   = 1'b0;
            ret_nxt        = (n_r == N_W'(MAX_RESULTS - 1)) ? S_LFIN : S_LSCAN;
          end
        end else if (!pend_v_r) begin
          res_ident_nxt  = '0;
          res_owner_nxt  = '0;
          res_status_nxt = STAT_NOT_FOUND;
          res_last_nxt   = 1'b1;
          ret_nxt        = S_IDLE;
        end
      end
      S_LFIN: begin
        res_ident_nxt  = pend_ident_r;
        res_owner_nxt  = pend_owner_r;
        res_status_nxt = STAT_OK;
        res_last_nxt   = 1'b1;
        ret_nxt        = S_IDLE;
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= RING_CW'(INITIAL_IDS);
      used_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      used_valid_r <= used_valid_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r        <= ret_nxt;
    type_r       <= type_nxt;
    owner_r      <= owner_nxt;
    ident_r      <= ident_nxt;
    cnt_r        <= cnt_nxt;
    chk_v_r      <= chk_v_nxt;
    chk_i_r      <= chk_i_nxt;
    slot_r       <= slot_nxt;
    found_r      <= found_nxt;
    n_r          <= n_nxt;
    prev_key_r   <= prev_key_nxt;
    have_prev_r  <= have_prev_nxt;
    best_key_r   <= best_key_nxt;
    best_owner_r <= best_owner_nxt;
    best_found_r <= best_found_nxt;
    pend_v_r     <= pend_v_nxt;
    pend_ident_r <= pend_ident_nxt;
    pend_owner_r <= pend_owner_nxt;
    res_ident_r  <= res_ident_nxt;
    res_owner_r  <= res_owner_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    if (load_out) begin
      out_ident_r  <= res_ident_r;
      out_owner_r  <= res_owner_r;
      out_status_r <= res_status_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ident  = out_ident_r;
  assign out_owner  = out_owner_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RING_CW'(RING_DEPTH))
    else $error("free count beyond ring depth");

  a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALWR) |=> (count_r == $past(count_r) - 1'b1))
    else $error("allocate did not pop one free ID");

  a_release_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELW) |=> (count_r == $past(count_r) + 1'b1))
    else $error("release did not append one free ID");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> out_valid_r)
    else $error("result item not loaded into output register");

  a_list_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LPASS && best_found_r && have_prev_r) |-> (best_key_r > prev_key_r))
    else $error("used listing out of order");

endmodule
